### rtl/byteplane_rle_decoder_unit_defines.svh
// assertion macros for the byte-plane run-length decoder
// no dependencies; included by files that check their own logic
`ifndef BYTEPLANE_RLE_DECODER_UNIT_DEFINES_SVH
`define BYTEPLANE_RLE_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BRLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("brle assertion failed");
`define BRLE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("brle assertion failed");
`else
`define BRLE_ASSERT(lbl, clk, rst_n, prop)
`define BRLE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/brle_pkg.sv
// shared types and constants for the byte-plane run-length decoder
// no dependencies
`default_nettype none
package brle_pkg;

    localparam int unsigned OFFSET_W = 18;
    localparam int unsigned POS_W    = 17;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned COUNT_W  = 8;

    localparam logic [7:0] CMD_LEN_MASK   = 8'h7F;
    localparam logic [7:0] CMD_REPEAT_BIT = 8'h80;

    typedef enum logic [2:0] {
        PH_HDR_LO = 3'd0,
        PH_HDR_HI = 3'd1,
        PH_CMD    = 3'd2,
        PH_LIT    = 3'd3,
        PH_REPVAL = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef struct packed {
        logic                valid;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          value;
        logic [COUNT_W-1:0]  count;
        logic                plane_sel;
        logic                stream_done;
    } t_result;

endpackage
`default_nettype wire

### rtl/brle_core.sv
// parse state and combinational decode of one stream byte
// depends on brle_pkg
`default_nettype none
module brle_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_byte,
    output brle_pkg::t_result     o_res,
    output brle_pkg::t_phase      o_phase
);

    brle_pkg::t_phase                 r_phase, n_phase;
    logic [brle_pkg::LEN_W-1:0]       r_len, n_len;
    logic                             r_idx, n_idx;
    logic [brle_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [brle_pkg::COUNT_W-1:0]     r_rem, n_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= brle_pkg::PH_HDR_LO;
            r_len   <= '0;
            r_idx   <= 1'b0;
            r_pos   <= '0;
            r_rem   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            r_rem   <= n_rem;
        end
    end

    // next state
    always_comb begin
        logic [brle_pkg::POS_W-1:0]   pos_sum;
        logic [brle_pkg::COUNT_W-1:0] rem_dec;
        logic                         finish;
        n_phase = r_phase;
        n_len   = r_len;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_rem   = r_rem;
        pos_sum = r_pos + {{(brle_pkg::POS_W-brle_pkg::COUNT_W){1'b0}}, r_rem};
        rem_dec = r_rem - 8'd1;
        finish  = 1'b0;
        case (r_phase)
            brle_pkg::PH_HDR_LO: begin
                n_len   = {8'd0, i_byte};
                n_phase = brle_pkg::PH_HDR_HI;
            end
            brle_pkg::PH_HDR_HI: begin
                n_len   = {i_byte, r_len[7:0]};
                n_idx   = 1'b0;
                n_pos   = '0;
                n_phase = ({i_byte, r_len[7:0]} == '0) ? brle_pkg::PH_DONE
                                                        : brle_pkg::PH_CMD;
            end
            brle_pkg::PH_CMD: begin
                n_rem   = (i_byte & brle_pkg::CMD_LEN_MASK) + 8'd1;
                n_phase = ((i_byte & brle_pkg::CMD_REPEAT_BIT) != 8'd0)
                          ? brle_pkg::PH_REPVAL : brle_pkg::PH_LIT;
            end
            brle_pkg::PH_LIT: begin
                pos_sum = r_pos + 17'd1;
                n_pos   = pos_sum;
                n_rem   = rem_dec;
                finish  = (rem_dec == '0);
            end
            brle_pkg::PH_REPVAL: begin
                n_pos  = pos_sum;
                n_rem  = '0;
                finish = 1'b1;
            end
            default: begin
                n_phase = brle_pkg::PH_DONE;
            end
        endcase
        if (finish) begin
            if (pos_sum >= {1'b0, r_len}) begin
                if (!r_idx) begin
                    n_idx   = 1'b1;
                    n_pos   = '0;
                    n_phase = brle_pkg::PH_CMD;
                end else begin
                    n_phase = brle_pkg::PH_DONE;
                end
            end else begin
                n_phase = brle_pkg::PH_CMD;
            end
        end
    end

    // result
    always_comb begin
        o_res             = '0;
        o_res.offset      = {r_pos, ~r_idx};
        o_res.value       = i_byte;
        o_res.plane_sel   = r_idx;
        o_res.stream_done = r_idx && (n_phase == brle_pkg::PH_DONE);
        case (r_phase)
            brle_pkg::PH_LIT: begin
                o_res.valid = 1'b1;
                o_res.count = 8'd1;
            end
            brle_pkg::PH_REPVAL: begin
                o_res.valid = 1'b1;
                o_res.count = r_rem;
            end
            default: begin
                o_res.valid = 1'b0;
                o_res.count = r_rem;
            end
        endcase
        if (!o_res.valid) begin
            o_res.stream_done = 1'b0;
        end
    end

    assign o_phase = r_phase;

endmodule
`default_nettype wire

### rtl/byteplane_rle_decoder_unit.sv
// Byte-plane run-length decoder. Takes compressed bytes on the slave stream
// and emits write runs (offset, value, count at stride two) on the master
// stream; tlast marks the run that completes the second plane and tuser
// carries the plane select. Each byte passes an input register, a
// combinational parse against the plane state and a result register, so
// a request is accepted every cycle while the output is not stalled.
// Bytes after completion are dropped.
// depends on brle_pkg, brle_core and byteplane_rle_decoder_unit_defines.svh
`default_nettype none
`include "byteplane_rle_decoder_unit_defines.svh"
module byteplane_rle_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [17:0] out_offset, [25:18] out_value,
                                             // [33:26] out_count, [39:34] zero
    output logic             m_axis_tlast,   // stream_done
    output logic             m_axis_tuser    // [0] plane_sel
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    brle_pkg::t_result r_out;
    logic              out_free;
    logic              fire;
    brle_pkg::t_result res;
    brle_pkg::t_phase  phase;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    brle_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_res   (res),
        .o_phase (phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.count, r_out.value, r_out.offset};
    assign m_axis_tlast  = r_out.stream_done;
    assign m_axis_tuser  = r_out.plane_sel;

    // a held byte stays put until it is decoded
    `BRLE_ASSERT(a_in_hold, i_clk, i_rst_n, r_in_valid && !fire |=> r_in_valid && $stable(r_in_byte))
    // nothing is produced once the stream is complete
    `BRLE_ASSERT(a_done_quiet, i_clk, i_rst_n, phase == brle_pkg::PH_DONE |-> !res.valid)
    // the final run always belongs to the second plane
    `BRLE_ASSERT(a_last_plane, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    // run lengths stay within one command
    `BRLE_ASSERT_ALWAYS(a_count_rng, i_clk, m_axis_tvalid |-> r_out.count != 8'd0 && r_out.count <= 8'd128)

endmodule
`default_nettype wire
